// ----- src/bcrp_pkg.sv -----
// bcrp_pkg: shared widths, codes and control/status types for the blob
// centroid recentring paste block. No dependencies; compile first.

package bcrp_pkg;

   // Payload and register widths
   localparam int COORD_W    = 10;   // pix_x / pix_y
   localparam int VALUE_W    = 8;    // grey values
   localparam int DIM_W      = 13;   // image_cols / image_rows
   localparam int BLOB_W     = 11;   // blob_cols / blob_rows
   localparam int LOC_W      = 12;   // blob_loc_x / blob_loc_y
   localparam int DEST_W     = 12;   // dest_x / dest_y
   localparam int SHIFT_W    = 14;   // shift_x / shift_y
   localparam int SUM_W      = 30;   // coordinate sums
   localparam int CNT_W      = 21;   // lit pixel count
   localparam int CENT_W     = 18;   // centroid, 10.8 unsigned
   localparam int FRAC_W     = 8;    // fraction bits of the centroid
   localparam int CALC_W     = 22;   // signed 8-fraction-bit placement words
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Largest image dimension a size register is clamped to
   localparam logic [DIM_W-1:0] MAX_IMAGE_DIM = 13'd4096;

   // Paint colour for white
   localparam logic [VALUE_W-1:0] WHITE_VALUE = 8'd255;

   // Divider: quotient is below 2^CENT_W since every column is below 2^COORD_W
   localparam int DIV_STEPS = CENT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Opcodes
   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_PLACE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAINT_WHITE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_BY_MASS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOB_COLS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOB_ROWS      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOB_LOC_X     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOB_LOC_Y     = 3'd7;

   // Configuration as seen by the datapath; image sizes already clamped
   typedef struct packed {
      logic [DIM_W-1:0]  dim_cols;
      logic [DIM_W-1:0]  dim_rows;
      logic              paint_white;
      logic              centre_by_mass;
      logic [BLOB_W-1:0] blob_cols;
      logic [BLOB_W-1:0] blob_rows;
      logic [LOC_W-1:0]  blob_loc_x;
      logic [LOC_W-1:0]  blob_loc_y;
   } cfg_type;

   // Controller -> datapath
   typedef struct packed {
      logic accum;      // live opcode-0 transfer: accumulate, post zero result
      logic capture;    // live opcode-1 transfer: latch pixel, load divider
      logic div_step;   // one restoring division step
      logic div_last;   // final step: commit centroid
      logic calc;       // placement stage one
      logic emit;       // placement stage two into output register
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic slot_free;  // output register empty or draining this cycle
      logic cent_ready; // centroid valid for the current job
   } stat_type;

endpackage

// ----- src/bcrp_req_if.sv -----
// bcrp_req_if: input pixel channel, valid/ready with the pixel payload.
// Depends on bcrp_pkg.

interface bcrp_req_if;
   import bcrp_pkg::*;

   logic               valid;
   logic               ready;
   logic               opcode;
   logic [COORD_W-1:0] pix_x;
   logic [COORD_W-1:0] pix_y;
   logic [VALUE_W-1:0] pix_value;

   modport source (output valid, output opcode, output pix_x, output pix_y,
                   output pix_value, input ready);
   modport sink   (input valid, input opcode, input pix_x, input pix_y,
                   input pix_value, output ready);
endinterface

// ----- src/bcrp_rsp_if.sv -----
// bcrp_rsp_if: result channel, valid/ready with the placement payload.
// Depends on bcrp_pkg.

interface bcrp_rsp_if;
   import bcrp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      write_enable;
   logic [DEST_W-1:0]         dest_x;
   logic [DEST_W-1:0]         dest_y;
   logic [VALUE_W-1:0]        write_value;
   logic signed [SHIFT_W-1:0] shift_x;
   logic signed [SHIFT_W-1:0] shift_y;

   modport source (output valid, output write_enable, output dest_x, output dest_y,
                   output write_value, output shift_x, output shift_y, input ready);
   modport sink   (input valid, input write_enable, input dest_x, input dest_y,
                   input write_value, input shift_x, input shift_y, output ready);
endinterface

// ----- src/bcrp_csr.sv -----
// bcrp_csr: configuration register file with write-only port.
// Image sizes are clamped to 1..MAX_IMAGE_DIM on write. Depends on bcrp_pkg.

module bcrp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bcrp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcrp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bcrp_pkg::cfg_type                cfg
);
   import bcrp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (v > MAX_IMAGE_DIM) begin
         return MAX_IMAGE_DIM;
      end
      return v;
   endfunction

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_COLS:     cfg_in.dim_cols       = dim_clamp(csr_wdata[DIM_W-1:0]);
            CSR_IMAGE_ROWS:     cfg_in.dim_rows       = dim_clamp(csr_wdata[DIM_W-1:0]);
            CSR_PAINT_WHITE:    cfg_in.paint_white    = csr_wdata[0];
            CSR_CENTRE_BY_MASS: cfg_in.centre_by_mass = csr_wdata[0];
            CSR_BLOB_COLS:      cfg_in.blob_cols      = csr_wdata[BLOB_W-1:0];
            CSR_BLOB_ROWS:      cfg_in.blob_rows      = csr_wdata[BLOB_W-1:0];
            CSR_BLOB_LOC_X:     cfg_in.blob_loc_x     = csr_wdata[LOC_W-1:0];
            CSR_BLOB_LOC_Y:     cfg_in.blob_loc_y     = csr_wdata[LOC_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_cols       <= DIM_W'(640);
         cfg_ff.dim_rows       <= DIM_W'(480);
         cfg_ff.paint_white    <= 1'b1;
         cfg_ff.centre_by_mass <= 1'b1;
         cfg_ff.blob_cols      <= BLOB_W'(64);
         cfg_ff.blob_rows      <= BLOB_W'(64);
         cfg_ff.blob_loc_x     <= '0;
         cfg_ff.blob_loc_y     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/bcrp_ctrl.sv -----
// bcrp_ctrl: job sequencer. Steps accept -> divide -> place -> emit and
// drives the datapath through cmd_type. Depends on bcrp_pkg.

module bcrp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_ready,
   input  bcrp_pkg::stat_type  stat,
   output bcrp_pkg::cmd_type   cmd
);
   import bcrp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [1:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.slot_free;
            if (req_valid && stat.slot_free) begin
               if (req_opcode == OP_ACCUM) begin
                  cmd.accum = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  step_in     = '0;
                  state_in    = stat.cent_ready ? ST_CALC : ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               cmd.div_last = 1'b1;
               state_in     = ST_CALC;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- src/bcrp_dp.sv -----
// bcrp_dp: datapath. Coordinate accumulators, two bit-serial restoring
// dividers, two-stage placement and the output register. Depends on bcrp_pkg.

module bcrp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bcrp_pkg::cmd_type                    cmd,
   output bcrp_pkg::stat_type                   stat,
   input  bcrp_pkg::cfg_type                    cfg,
   input  logic [bcrp_pkg::COORD_W-1:0]         in_pix_x,
   input  logic [bcrp_pkg::COORD_W-1:0]         in_pix_y,
   input  logic [bcrp_pkg::VALUE_W-1:0]         in_pix_value,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_write_enable,
   output logic [bcrp_pkg::DEST_W-1:0]          rsp_dest_x,
   output logic [bcrp_pkg::DEST_W-1:0]          rsp_dest_y,
   output logic [bcrp_pkg::VALUE_W-1:0]         rsp_write_value,
   output logic signed [bcrp_pkg::SHIFT_W-1:0]  rsp_shift_x,
   output logic signed [bcrp_pkg::SHIFT_W-1:0]  rsp_shift_y
);
   import bcrp_pkg::*;

   localparam int REM_W  = CNT_W;                 // remainder stays below count
   localparam int DLO_W  = DIV_STEPS;             // dividend bits shifted in
   localparam int DHI_W  = SUM_W + FRAC_W - DLO_W; // dividend bits preloaded
   localparam int HALF_W = DIM_W - 1;

   // job state
   logic [SUM_W-1:0]  sum_cols_ff, sum_cols_in;
   logic [SUM_W-1:0]  sum_rows_ff, sum_rows_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CENT_W-1:0] cent_col_ff, cent_col_in;
   logic [CENT_W-1:0] cent_row_ff, cent_row_in;
   logic              cent_ready_ff, cent_ready_in;

   // divider
   logic [REM_W-1:0]  rem_col_ff, rem_col_in;
   logic [REM_W-1:0]  rem_row_ff, rem_row_in;
   logic [DLO_W-1:0]  dlo_col_ff, dlo_col_in;
   logic [DLO_W-1:0]  dlo_row_ff, dlo_row_in;

   // captured pass-two pixel
   logic [COORD_W-1:0] cap_x_ff, cap_x_in;
   logic [COORD_W-1:0] cap_y_ff, cap_y_in;
   logic [VALUE_W-1:0] cap_value_ff, cap_value_in;

   // placement stage one (signed, 8 fraction bits)
   logic [CALC_W-1:0] pos_vx_ff, pos_vx_in;
   logic [CALC_W-1:0] pos_vy_ff, pos_vy_in;
   logic [CALC_W-1:0] shf_vx_ff, shf_vx_in;
   logic [CALC_W-1:0] shf_vy_ff, shf_vy_in;

   // output register
   logic                      out_vld_ff, out_vld_in;
   logic                      out_we_ff, out_we_in;
   logic [DEST_W-1:0]         out_dx_ff, out_dx_in;
   logic [DEST_W-1:0]         out_dy_ff, out_dy_in;
   logic [VALUE_W-1:0]        out_wv_ff, out_wv_in;
   logic signed [SHIFT_W-1:0] out_sx_ff, out_sx_in;
   logic signed [SHIFT_W-1:0] out_sy_ff, out_sy_in;

   logic               job_clear, lit;
   logic [SUM_W-1:0]   base_cols, base_rows;
   logic [CNT_W-1:0]   base_count;
   logic [REM_W:0]     step_col, step_row;
   logic [HALF_W-1:0]  half_c, half_r;
   logic [CENT_W-1:0]  sub_x, sub_y;
   logic [DIM_W-1:0]   ax, ay;
   logic [SHIFT_W-1:0] dx, dy;
   logic [VALUE_W-1:0] colour;
   logic               we;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                               input logic             nbit,
                                               input logic [CNT_W-1:0] dvs);
      logic [REM_W:0] trial;
      logic           ge;
      trial = {rem, nbit};
      ge    = trial >= {1'b0, dvs};
      if (ge) begin
         trial = trial - {1'b0, dvs};
      end
      return {ge, trial[REM_W-1:0]};
   endfunction

   // floor to integer, clamp into 0 .. dim-1
   function automatic logic [DEST_W-1:0] clamp_pos(input logic [CALC_W-1:0] v,
                                                   input logic [DIM_W-1:0]  dim);
      logic [SHIFT_W-1:0] p;
      logic [DIM_W-1:0]   top;
      p   = v[CALC_W-1:FRAC_W];
      top = dim - 1'b1;
      if (p[SHIFT_W-1]) begin
         return '0;
      end else if (p >= {1'b0, dim}) begin
         return top[DEST_W-1:0];
      end
      return p[DEST_W-1:0];
   endfunction

   // drop the fraction, rounding toward zero
   function automatic logic [SHIFT_W-1:0] trunc_frac(input logic [CALC_W-1:0] v);
      logic [CALC_W-1:0] adj;
      adj = v;
      if (v[CALC_W-1]) begin
         adj = v + CALC_W'(255);
      end
      return adj[CALC_W-1:FRAC_W];
   endfunction

   always_comb begin
      // accumulation; an opcode-0 transfer after a finished centroid opens a new job
      job_clear  = cent_ready_ff;
      base_cols  = job_clear ? '0 : sum_cols_ff;
      base_rows  = job_clear ? '0 : sum_rows_ff;
      base_count = job_clear ? '0 : count_ff;
      lit        = (in_pix_value != '0) && !base_count[CNT_W-1];

      step_col = div_step(rem_col_ff, dlo_col_ff[DLO_W-1], count_ff);
      step_row = div_step(rem_row_ff, dlo_row_ff[DLO_W-1], count_ff);

      // placement stage one operands
      half_c = cfg.dim_cols[DIM_W-1:1];
      half_r = cfg.dim_rows[DIM_W-1:1];
      sub_x  = cfg.centre_by_mass ? cent_col_ff : {cfg.blob_cols[BLOB_W-1:1], 8'b0};
      sub_y  = cfg.centre_by_mass ? cent_row_ff : {cfg.blob_rows[BLOB_W-1:1], 8'b0};
      ax     = DIM_W'(cap_x_ff) + DIM_W'(half_c);
      ay     = DIM_W'(cap_y_ff) + DIM_W'(half_r);
      dx     = SHIFT_W'(half_c) - SHIFT_W'(cfg.blob_loc_x);
      dy     = SHIFT_W'(half_r) - SHIFT_W'(cfg.blob_loc_y);

      colour = cfg.paint_white ? WHITE_VALUE : '0;
      we     = cap_value_ff == colour;

      sum_cols_in   = sum_cols_ff;
      sum_rows_in   = sum_rows_ff;
      count_in      = count_ff;
      cent_col_in   = cent_col_ff;
      cent_row_in   = cent_row_ff;
      cent_ready_in = cent_ready_ff;
      rem_col_in    = rem_col_ff;
      rem_row_in    = rem_row_ff;
      dlo_col_in    = dlo_col_ff;
      dlo_row_in    = dlo_row_ff;
      cap_x_in      = cap_x_ff;
      cap_y_in      = cap_y_ff;
      cap_value_in  = cap_value_ff;
      pos_vx_in     = pos_vx_ff;
      pos_vy_in     = pos_vy_ff;
      shf_vx_in     = shf_vx_ff;
      shf_vy_in     = shf_vy_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;
      out_we_in     = out_we_ff;
      out_dx_in     = out_dx_ff;
      out_dy_in     = out_dy_ff;
      out_wv_in     = out_wv_ff;
      out_sx_in     = out_sx_ff;
      out_sy_in     = out_sy_ff;

      if (cmd.accum) begin
         sum_cols_in   = base_cols + (lit ? SUM_W'(in_pix_x) : '0);
         sum_rows_in   = base_rows + (lit ? SUM_W'(in_pix_y) : '0);
         count_in      = base_count + CNT_W'(lit);
         cent_col_in   = '0;
         cent_row_in   = '0;
         cent_ready_in = 1'b0;
         out_vld_in    = 1'b1;
         out_we_in     = 1'b0;
         out_dx_in     = '0;
         out_dy_in     = '0;
         out_wv_in     = '0;
         out_sx_in     = '0;
         out_sy_in     = '0;
      end

      if (cmd.capture) begin
         cap_x_in     = in_pix_x;
         cap_y_in     = in_pix_y;
         cap_value_in = in_pix_value;
         // quotient fits CENT_W bits, so the top dividend bits are below the count
         rem_col_in   = REM_W'(sum_cols_ff[SUM_W-1:SUM_W-DHI_W]);
         rem_row_in   = REM_W'(sum_rows_ff[SUM_W-1:SUM_W-DHI_W]);
         dlo_col_in   = {sum_cols_ff[SUM_W-DHI_W-1:0], FRAC_W'(0)};
         dlo_row_in   = {sum_rows_ff[SUM_W-DHI_W-1:0], FRAC_W'(0)};
      end

      if (cmd.div_step) begin
         rem_col_in  = step_col[REM_W-1:0];
         rem_row_in  = step_row[REM_W-1:0];
         dlo_col_in  = dlo_col_ff << 1;
         dlo_row_in  = dlo_row_ff << 1;
         cent_col_in = {cent_col_ff[CENT_W-2:0], step_col[REM_W]};
         cent_row_in = {cent_row_ff[CENT_W-2:0], step_row[REM_W]};
         if (cmd.div_last) begin
            cent_ready_in = 1'b1;
            if (count_ff == '0) begin
               cent_col_in = '0;
               cent_row_in = '0;
            end
         end
      end

      if (cmd.calc) begin
         pos_vx_in = {1'b0, ax, FRAC_W'(0)} - CALC_W'(sub_x);
         pos_vy_in = {1'b0, ay, FRAC_W'(0)} - CALC_W'(sub_y);
         shf_vx_in = {dx, FRAC_W'(0)} - CALC_W'(sub_x);
         shf_vy_in = {dy, FRAC_W'(0)} - CALC_W'(sub_y);
      end

      if (cmd.emit) begin
         out_vld_in = 1'b1;
         out_we_in  = we;
         out_dx_in  = clamp_pos(pos_vx_ff, cfg.dim_cols);
         out_dy_in  = clamp_pos(pos_vy_ff, cfg.dim_rows);
         out_wv_in  = we ? colour : '0;
         out_sx_in  = trunc_frac(shf_vx_ff);
         out_sy_in  = trunc_frac(shf_vy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_cols_ff   <= '0;
         sum_rows_ff   <= '0;
         count_ff      <= '0;
         cent_col_ff   <= '0;
         cent_row_ff   <= '0;
         cent_ready_ff <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         sum_cols_ff   <= sum_cols_in;
         sum_rows_ff   <= sum_rows_in;
         count_ff      <= count_in;
         cent_col_ff   <= cent_col_in;
         cent_row_ff   <= cent_row_in;
         cent_ready_ff <= cent_ready_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_col_ff   <= rem_col_in;
      rem_row_ff   <= rem_row_in;
      dlo_col_ff   <= dlo_col_in;
      dlo_row_ff   <= dlo_row_in;
      cap_x_ff     <= cap_x_in;
      cap_y_ff     <= cap_y_in;
      cap_value_ff <= cap_value_in;
      pos_vx_ff    <= pos_vx_in;
      pos_vy_ff    <= pos_vy_in;
      shf_vx_ff    <= shf_vx_in;
      shf_vy_ff    <= shf_vy_in;
      out_we_ff    <= out_we_in;
      out_dx_ff    <= out_dx_in;
      out_dy_ff    <= out_dy_in;
      out_wv_ff    <= out_wv_in;
      out_sx_ff    <= out_sx_in;
      out_sy_ff    <= out_sy_in;
   end

   assign stat.slot_free  = !out_vld_ff || rsp_ready;
   assign stat.cent_ready = cent_ready_ff;

   assign rsp_valid        = out_vld_ff;
   assign rsp_write_enable = out_we_ff;
   assign rsp_dest_x       = out_dx_ff;
   assign rsp_dest_y       = out_dy_ff;
   assign rsp_write_value  = out_wv_ff;
   assign rsp_shift_x      = out_sx_ff;
   assign rsp_shift_y      = out_sy_ff;

endmodule

// ----- src/blob_centroid_recentre_paste.sv -----
// Pass-one pixel: result in the output register the cycle after the transfer;
//   one transfer per cycle while the result side keeps up.
// Pass-two pixel: transfer, placement add, clamp/emit, one pixel at a time.
//   The first one of a job first runs the two bit-serial centroid dividers
//   (one quotient bit per cycle).
// Reset (synchronous, active high): clears sums, count, centroid and the
//   output register; config returns to its defaults. No memory to sweep.

module blob_centroid_recentre_paste (
   input  logic                               clock,
   input  logic                               reset,
   bcrp_req_if.sink                           req_bus,
   bcrp_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [bcrp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bcrp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bcrp_pkg::*;

   cfg_type  cfg;    // live config, image sizes pre-clamped
   cmd_type  cmd;    // sequencer strobes
   stat_type stat;   // output slot and centroid status

   // Register file: written any time the block is idle, no read-back.
   bcrp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: req ready only in idle and when the output slot can take
   // a result this cycle (a pass-one transfer posts its zero result at once).
   bcrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: sums and count per job, centroid divide once per job,
   // placement in two register stages, then the registered result.
   bcrp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg              (cfg),
      .in_pix_x         (req_bus.pix_x),
      .in_pix_y         (req_bus.pix_y),
      .in_pix_value     (req_bus.pix_value),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_write_enable (rsp_bus.write_enable),
      .rsp_dest_x       (rsp_bus.dest_x),
      .rsp_dest_y       (rsp_bus.dest_y),
      .rsp_write_value  (rsp_bus.write_value),
      .rsp_shift_x      (rsp_bus.shift_x),
      .rsp_shift_y      (rsp_bus.shift_y)
   );

endmodule

// ----- src/bcrp_chk.sv -----
// bcrp_chk: port-level checks for blob_centroid_recentre_paste, bound to
// the top level below. Depends on bcrp_pkg and the top level.

module bcrp_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_opcode,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_write_enable,
   input logic [bcrp_pkg::DEST_W-1:0]        rsp_dest_x,
   input logic [bcrp_pkg::DEST_W-1:0]        rsp_dest_y,
   input logic [bcrp_pkg::VALUE_W-1:0]       rsp_write_value,
   input logic signed [bcrp_pkg::SHIFT_W-1:0] rsp_shift_x,
   input logic signed [bcrp_pkg::SHIFT_W-1:0] rsp_shift_y
);
   import bcrp_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // a pending result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // pass-one transfer posts an all-zero result on the next cycle
   a_accum_zero: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_opcode == OP_ACCUM |=>
         rsp_valid && !rsp_write_enable && rsp_dest_x == '0 && rsp_dest_y == '0 &&
         rsp_write_value == '0 && rsp_shift_x == '0 && rsp_shift_y == '0)
      else $error("pass-one result missing or not zero");

   // pass-two pixels are worked one at a time
   a_place_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_opcode == OP_PLACE |=> !req_ready)
      else $error("new pixel taken while placement busy");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind blob_centroid_recentre_paste bcrp_chk u_bcrp_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_opcode       (req_bus.opcode),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_write_enable (rsp_bus.write_enable),
   .rsp_dest_x       (rsp_bus.dest_x),
   .rsp_dest_y       (rsp_bus.dest_y),
   .rsp_write_value  (rsp_bus.write_value),
   .rsp_shift_x      (rsp_bus.shift_x),
   .rsp_shift_y      (rsp_bus.shift_y)
);
